// File: design/spq_pkg.sv
// shared types and constants for the sorted priority queue
// no dependencies
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PAY_W    = 32;
    localparam int PRI_W    = 16;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_PEEK    = 2'd1;
    localparam logic [1:0] OP_DEQUEUE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [PRI_W-1:0] pri;
        logic [PAY_W-1:0]        pay;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic deq;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/spq_cell.sv
// one slot of the sorted chain: holds an entry, shifts toward tail on insert,
// toward head on dequeue
// depends on spq_pkg
`default_nettype none

module spq_cell (
    input  wire logic                    clk,
    input  wire spq_pkg::cell_ctrl_t     ctrl,
    input  wire logic                    occupied,
    input  wire spq_pkg::entry_t         new_ent,
    input  wire logic                    prev_take,
    input  wire spq_pkg::entry_t         prev_ent,
    input  wire spq_pkg::entry_t         next_ent,
    output logic                         take,
    output spq_pkg::entry_t              ent
);

    spq_pkg::entry_t ent_reg;
    spq_pkg::entry_t ent_next;

    // new entry goes ahead of the first strictly lower priority
    assign take = !occupied || ($signed(new_ent.pri) > $signed(ent_reg.pri));
    assign ent  = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctrl.ins && take)
        begin
            ent_next = prev_take ? prev_ent : new_ent;
        end
        else if (ctrl.deq)
        begin
            ent_next = next_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

// File: design/sorted_priority_queue_unit.sv
// sorted priority queue: a chain of CAPACITY cells kept in priority order, head at cell 0
// result: registered, valid in the cycle after the input beat is accepted
// throughput: one operation per cycle while the result side does not stall
// reset: entry count cleared and result valid dropped; stored entries stay undefined until written
// depends on spq_pkg and spq_cell
`default_nettype none

module sorted_priority_queue_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    op,
    input  wire logic [spq_pkg::PAY_W-1:0]     payload,
    input  wire logic signed [spq_pkg::PRI_W-1:0] priority_req,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [spq_pkg::PAY_W-1:0]          out_payload,
    output logic signed [spq_pkg::PRI_W-1:0]   out_priority,
    output logic [1:0]                         status,
    output logic                               is_empty,
    output logic                               is_full
);

    localparam int N = spq_pkg::CAPACITY;

    logic [spq_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                             out_valid_reg, out_valid_next;
    logic [spq_pkg::PAY_W-1:0]        out_payload_reg, out_payload_next;
    logic signed [spq_pkg::PRI_W-1:0] out_priority_reg, out_priority_next;
    logic [1:0]                       status_reg, status_next;
    logic                             is_empty_reg, is_empty_next;
    logic                             is_full_reg, is_full_next;

    logic                accept;
    logic                q_empty;
    logic                q_full;
    spq_pkg::cell_ctrl_t ctrl;
    spq_pkg::entry_t     new_ent;
    spq_pkg::entry_t     ents [N];
    logic [N-1:0]        takes;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign q_empty  = (count_reg == '0);
    assign q_full   = (count_reg == spq_pkg::CNT_W'(N));

    assign ctrl.ins    = accept && (op == spq_pkg::OP_INSERT) && !q_full;
    assign ctrl.deq    = accept && (op == spq_pkg::OP_DEQUEUE) && !q_empty;
    assign new_ent.pri = priority_req;
    assign new_ent.pay = payload;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            spq_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (count_reg > spq_pkg::CNT_W'(i)),
                .new_ent   (new_ent),
                .prev_take ((i == 0) ? 1'b0 : takes[(i == 0) ? 0 : i - 1]),
                .prev_ent  ((i == 0) ? new_ent : ents[(i == 0) ? 0 : i - 1]),
                .next_ent  ((i == N - 1) ? ents[i] : ents[(i == N - 1) ? i : i + 1]),
                .take      (takes[i]),
                .ent       (ents[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next        = count_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_payload_next  = out_payload_reg;
        out_priority_next = out_priority_reg;
        status_next       = status_reg;
        is_empty_next     = is_empty_reg;
        is_full_next      = is_full_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - 1'b1;
        end
        if (accept)
        begin
            out_valid_next    = 1'b1;
            out_payload_next  = '0;
            out_priority_next = '0;
            status_next       = spq_pkg::ST_OK;
            case (op)
                spq_pkg::OP_INSERT:
                begin
                    if (q_full)
                    begin
                        status_next = spq_pkg::ST_FULL;
                    end
                end
                spq_pkg::OP_PEEK, spq_pkg::OP_DEQUEUE:
                begin
                    if (q_empty)
                    begin
                        status_next = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        out_payload_next  = ents[0].pay;
                        out_priority_next = ents[0].pri;
                    end
                end
                default:
                begin
                    status_next = spq_pkg::ST_OK;
                end
            endcase
            is_empty_next = (count_next == '0);
            is_full_next  = (count_next == spq_pkg::CNT_W'(N));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_payload_reg  <= out_payload_next;
        out_priority_reg <= out_priority_next;
        status_reg       <= status_next;
        is_empty_reg     <= is_empty_next;
        is_full_reg      <= is_full_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_payload  = out_payload_reg;
    assign out_priority = out_priority_reg;
    assign status       = status_reg;
    assign is_empty     = is_empty_reg;
    assign is_full      = is_full_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::CNT_W'(N))
        else $error("entry count beyond capacity");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat produced no result");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == spq_pkg::OP_INSERT && q_full)
        |=> (status_reg == spq_pkg::ST_FULL) && $stable(count_reg))
        else $error("insert into full queue not rejected");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= spq_pkg::CNT_W'(2)) |-> ($signed(ents[0].pri) >= $signed(ents[1].pri)))
        else $error("head entry out of priority order");

endmodule

`default_nettype wire

// File: bench/spq_checker.sv
// result checker for the sorted priority queue: watches both channels, keeps its own copy
// of the queue contents and compares every result beat against the predicted reply
// depends on spq_pkg
module spq_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_stall,
    input  wire logic [1:0]                         op,
    input  wire logic [spq_pkg::PAY_W-1:0]          payload,
    input  wire logic signed [spq_pkg::PRI_W-1:0]   priority_req,
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire logic [spq_pkg::PAY_W-1:0]          out_payload,
    input  wire logic signed [spq_pkg::PRI_W-1:0]   out_priority,
    input  wire logic [1:0]                         status,
    input  wire logic                               is_empty,
    input  wire logic                               is_full,
    output int                                      mismatch_count,
    output int                                      replies_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [spq_pkg::PAY_W-1:0]        pay;
        logic signed [spq_pkg::PRI_W-1:0] pri;
        logic [1:0]                       stat;
        logic                             empty;
        logic                             full;
    } queue_reply_t;

    logic signed [spq_pkg::PRI_W-1:0] slot_pri [spq_pkg::CAPACITY];
    logic [spq_pkg::PAY_W-1:0]        slot_pay [spq_pkg::CAPACITY];
    int                               held = 0;
    int                               errors = 0;
    queue_reply_t                     pending_replies [$];

    function automatic queue_reply_t apply_queue_op(logic [1:0] code,
                                                    logic [spq_pkg::PAY_W-1:0] pay,
                                                    logic signed [spq_pkg::PRI_W-1:0] pri);
        queue_reply_t r;
        int pos;
        int i;
        r = '0;
        r.stat = spq_pkg::ST_OK;
        if (code == spq_pkg::OP_INSERT)
        begin
            if (held >= spq_pkg::CAPACITY)
            begin
                r.stat = spq_pkg::ST_FULL;
            end
            else
            begin
                pos = held;
                for (i = held - 1; i >= 0; i--)
                begin
                    if (pri > slot_pri[i])
                    begin
                        pos = i;
                    end
                end
                for (i = held; i > pos; i--)
                begin
                    slot_pri[i] = slot_pri[i-1];
                    slot_pay[i] = slot_pay[i-1];
                end
                slot_pri[pos] = pri;
                slot_pay[pos] = pay;
                held++;
            end
        end
        else if (code == spq_pkg::OP_PEEK || code == spq_pkg::OP_DEQUEUE)
        begin
            if (held == 0)
            begin
                r.stat = spq_pkg::ST_EMPTY;
            end
            else
            begin
                r.pay = slot_pay[0];
                r.pri = slot_pri[0];
                if (code == spq_pkg::OP_DEQUEUE)
                begin
                    for (i = 1; i < held; i++)
                    begin
                        slot_pri[i-1] = slot_pri[i];
                        slot_pay[i-1] = slot_pay[i];
                    end
                    held--;
                end
            end
        end
        r.empty = (held == 0);
        r.full  = (held >= spq_pkg::CAPACITY);
        return r;
    endfunction

    task automatic check_reply();
        queue_reply_t want;
        if (pending_replies.size() == 0)
        begin
            if (errors < 10)
            begin
                $display("%0t: unexpected result beat: pay %h pri %0d status %0d empty %b full %b",
                         $realtime, out_payload, out_priority, status, is_empty, is_full);
            end
            errors++;
        end
        else
        begin
            want = pending_replies.pop_front();
            if (out_payload !== want.pay || out_priority !== want.pri || status !== want.stat ||
                is_empty !== want.empty || is_full !== want.full)
            begin
                if (errors < 10)
                begin
                    $display("%0t: mismatch: expected pay %h pri %0d status %0d empty %b full %b",
                             $realtime, want.pay, want.pri, want.stat, want.empty, want.full);
                    $display("%0t:           actual   pay %h pri %0d status %0d empty %b full %b",
                             $realtime, out_payload, out_priority, status, is_empty, is_full);
                end
                errors++;
            end
        end
    endtask

    // result side first: a beat leaving now belongs to an earlier input beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                check_reply();
            end
            if (in_valid && !in_stall)
            begin
                pending_replies.push_back(apply_queue_op(op, payload, priority_req));
            end
        end
        mismatch_count <= errors;
        replies_due <= pending_replies.size();
    end

endmodule

// File: bench/tb_sorted_priority_queue_unit.sv
// top of the sorted priority queue regression: clock, reset, directed and random operation
// traffic with random gaps and result stalls, and the final verdict
// depends on spq_pkg, sorted_priority_queue_unit and spq_checker
module tb_sorted_priority_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         RAND_ITEMS = 1700;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [1:0]                       op;
    logic [spq_pkg::PAY_W-1:0]        payload;
    logic signed [spq_pkg::PRI_W-1:0] priority_req;
    logic                             out_valid;
    logic                             out_stall;
    logic [spq_pkg::PAY_W-1:0]        out_payload;
    logic signed [spq_pkg::PRI_W-1:0] out_priority;
    logic [1:0]                       status;
    logic                             is_empty;
    logic                             is_full;
    int                               mismatch_count;
    int                               replies_due;

    sorted_priority_queue_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .payload      (payload),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_payload  (out_payload),
        .out_priority (out_priority),
        .status       (status),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    spq_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .payload        (payload),
        .priority_req   (priority_req),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_payload    (out_payload),
        .out_priority   (out_priority),
        .status         (status),
        .is_empty       (is_empty),
        .is_full        (is_full),
        .mismatch_count (mismatch_count),
        .replies_due    (replies_due)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [spq_pkg::PRI_W-1:0] pick_priority();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            v = $urandom_range(0, 8);
            v = v - 4;
            return v[spq_pkg::PRI_W-1:0];
        end
        else if (r < 50)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h8001;
                default: return 16'h7FFE;
            endcase
        end
        v = $urandom();
        return v[spq_pkg::PRI_W-1:0];
    endfunction

    function automatic logic [spq_pkg::PAY_W-1:0] pick_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            return '0;
        end
        else if (r < 4)
        begin
            return '1;
        end
        return $urandom();
    endfunction

    task automatic issue_op(input logic [1:0] code, input logic [spq_pkg::PAY_W-1:0] pay,
                            input logic [spq_pkg::PRI_W-1:0] pri, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= code;
        payload      <= pay;
        priority_req <= pri;
        do @(posedge clk); while (in_stall);
    endtask

    // result side stall pattern: short and long stalls, free-running stretches
    initial
    begin
        int run;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) < 35)
            begin
                out_stall <= 1'b1;
                run = pick_gap();
            end
            else
            begin
                out_stall <= 1'b0;
                run = ($urandom_range(0, 99) < 15) ? $urandom_range(20, 100)
                                                    : $urandom_range(0, 6);
            end
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin
        #4_000_000;
        $display("sorted_priority_queue_unit regression: fail");
        $finish;
    end

    initial
    begin
        logic [spq_pkg::PRI_W-1:0] fill_pri [16];
        logic [1:0]                code;
        int                        sent;
        int                        burst;
        int                        lean;
        int                        roll;
        bit                        calm;

        fill_pri = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h0005, 16'h0005,
                     16'h0005, 16'h8000, 16'h7FFF, 16'h0064, 16'hFF9C, 16'h0000, 16'h4000,
                     16'hC000, 16'h0002};
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        op           <= OP_UNUSED;
        payload      <= '0;
        priority_req <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corner cases
        issue_op(spq_pkg::OP_PEEK, '1, 16'h7FFF, 0);
        issue_op(spq_pkg::OP_DEQUEUE, '1, 16'h8000, 0);
        issue_op(OP_UNUSED, 32'hA5A5A5A5, 16'h1234, 0);

        // fill with extremes and repeated priorities
        for (int i = 0; i < 16; i++)
        begin
            issue_op(spq_pkg::OP_INSERT, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFFFFFF : $urandom(),
                     fill_pri[i], (i % 5 == 4) ? 2 : 0);
        end
        issue_op(spq_pkg::OP_INSERT, 32'h55555555, 16'h7FFF, 0);
        issue_op(OP_UNUSED, 32'hAAAAAAAA, 16'hFFFF, 0);
        issue_op(spq_pkg::OP_PEEK, '0, '0, 0);
        issue_op(spq_pkg::OP_DEQUEUE, '0, '0, 0);
        issue_op(spq_pkg::OP_DEQUEUE, '0, '0, 1);

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            burst = $urandom_range(8, 48);
            lean  = $urandom_range(0, 3);
            calm  = ($urandom_range(0, 4) == 0);
            repeat (burst)
            begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 4)
                begin
                    code = OP_UNUSED;
                end
                else if (lean == 0)
                begin
                    code = (roll < 75) ? spq_pkg::OP_INSERT
                         : (roll < 85) ? spq_pkg::OP_PEEK : spq_pkg::OP_DEQUEUE;
                end
                else if (lean == 1)
                begin
                    code = (roll < 20) ? spq_pkg::OP_INSERT
                         : (roll < 35) ? spq_pkg::OP_PEEK : spq_pkg::OP_DEQUEUE;
                end
                else
                begin
                    code = (roll < 45) ? spq_pkg::OP_INSERT
                         : (roll < 65) ? spq_pkg::OP_PEEK : spq_pkg::OP_DEQUEUE;
                end
                issue_op(code, pick_payload(), pick_priority(), calm ? 0 : pick_gap());
                sent++;
            end
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (replies_due != 0);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && replies_due == 0)
        begin
            $display("sorted_priority_queue_unit regression: pass");
        end
        else
        begin
            $display("sorted_priority_queue_unit regression: fail");
        end
        $finish;
    end

endmodule
